// File: rtl/ulsm_pkg.sv
package ulsm_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_KERNEL = 9;

    localparam logic [1:0] OP_COEF  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_KERNEL_LENGTH = 2'd2;
    localparam logic [1:0] REG_SHARPEN_GAIN  = 2'd3;

    localparam int SRC_W   = 16;
    localparam int COEF_W  = 16;
    localparam int FILT_W  = 40;
    localparam int GAIN_W  = 16;
    localparam int OUT_W   = 22;
    localparam int PROD_W  = COEF_W + SRC_W + 1;
    localparam int T1_W    = FILT_W + SRC_W;
    localparam int T2_W    = T1_W + GAIN_W;
    localparam int QUOT_W  = T2_W - FILT_W;
    localparam int DIV_CW  = $clog2(QUOT_W);
    localparam int RND_SH  = 12;
    localparam int DELTA_W = QUOT_W + 1 - RND_SH;
    localparam int SUM_W   = OUT_W + 2;

    localparam logic [QUOT_W:0]         ROUND_BIAS = (QUOT_W + 1)'(2048);
    localparam logic signed [SUM_W-1:0] OUT_MAX    = SUM_W'(2097151);
    localparam logic signed [SUM_W-1:0] OUT_MIN    = -SUM_W'(2097152);

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: rtl/ulsm_div.sv
module ulsm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ulsm_pkg::T2_W-1:0]   num,
    input  logic [ulsm_pkg::FILT_W-1:0] den,
    output logic [ulsm_pkg::QUOT_W-1:0] quot,
    output ulsm_pkg::unit_stat_t        stat
);
    import ulsm_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [FILT_W-1:0]   rem_reg, rem_next;
    logic [QUOT_W-1:0]   q_reg, q_next;
    logic [FILT_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        trial     = {rem_reg, q_reg[QUOT_W-1]};
        if (start)
        begin
            // quotient fits QUOT_W bits, so the upper part is already below den
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num[T2_W-1:QUOT_W];
            q_next    = num[QUOT_W-1:0];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = FILT_W'(trial - {1'b0, den});
                q_next   = {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[FILT_W-1:0];
                q_next   = {q_reg[QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign quot      = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/ulsm_conv.sv
module ulsm_conv #(
    parameter int MAX_WIDTH  = ulsm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ulsm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = ulsm_pkg::DEF_MAX_KERNEL
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           start,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]                 img_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]                img_h,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]                klen,
    input  logic                                           coef_we,
    input  logic [$clog2(MAX_KERNEL*MAX_KERNEL)-1:0]       coef_addr,
    input  logic signed [ulsm_pkg::COEF_W-1:0]             coef_data,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]        src_addr,
    input  logic [ulsm_pkg::SRC_W-1:0]                     src_data,
    output logic                                           filt_we,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]        filt_addr,
    output logic [ulsm_pkg::FILT_W-1:0]                    filt_data,
    output logic [ulsm_pkg::SRC_W-1:0]                     max_src,
    output logic [ulsm_pkg::FILT_W-1:0]                    max_abs,
    output ulsm_pkg::unit_stat_t                           stat
);
    import ulsm_pkg::*;

    localparam int WB     = $clog2(MAX_WIDTH + 1);
    localparam int HB     = $clog2(MAX_HEIGHT + 1);
    localparam int LB     = $clog2(MAX_KERNEL + 1);
    localparam int XB     = $clog2(MAX_WIDTH);
    localparam int YB     = $clog2(MAX_HEIGHT);
    localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int KB     = $clog2(KDEPTH);
    localparam int PB     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int SXW    = WB + 2;
    localparam int SYW    = HB + 2;

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_RUN   = 2'd1;
    localparam logic [1:0] C_DRAIN = 2'd2;

    logic [COEF_W-1:0] kmem [KDEPTH];
    logic signed [COEF_W-1:0] ker_q;

    logic [1:0]   state_reg, state_next;
    logic [XB-1:0] x_reg, x_next;
    logic [YB-1:0] y_reg, y_next;
    logic [LB-1:0] i_reg, i_next, j_reg, j_next;
    logic [KB-1:0] k_reg, k_next;
    logic [PB-1:0] pix_reg, pix_next;

    logic          p1_valid_reg, p2_valid_reg;
    logic          p1_first_reg, p1_last_reg, p1_center_reg;
    logic          p2_first_reg, p2_last_reg;
    logic [PB-1:0] p1_pix_reg, p2_pix_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [FILT_W-1:0] acc_reg, acc_next;
    logic [FILT_W-1:0]        acc_abs;
    logic [SRC_W-1:0]         max_src_reg;
    logic [FILT_W-1:0]        max_abs_reg;

    logic [LB-1:0]  anchor, klast;
    logic           tap_last, col_last, row_last, issue;
    logic [SXW-1:0] sx_s;
    logic [SYW-1:0] sy_s;
    logic [WB-1:0]  sx;
    logic [HB-1:0]  sy;

    assign anchor   = (klen - 1'b1) >> 1;
    assign klast    = klen - 1'b1;
    assign issue    = (state_reg == C_RUN);
    assign tap_last = (i_reg == klast) && (j_reg == klast);
    assign col_last = (WB'(x_reg) == img_w - 1'b1);
    assign row_last = (HB'(y_reg) == img_h - 1'b1);

    // replicate the border: clamp the tap coordinate into the image
    always_comb
    begin
        sx_s = SXW'(x_reg) + SXW'(anchor) - SXW'(j_reg);
        sy_s = SYW'(y_reg) + SYW'(anchor) - SYW'(i_reg);
        if (sx_s[SXW-1])
            sx = '0;
        else if (sx_s >= SXW'(img_w))
            sx = img_w - 1'b1;
        else
            sx = WB'(sx_s);
        if (sy_s[SYW-1])
            sy = '0;
        else if (sy_s >= SYW'(img_h))
            sy = img_h - 1'b1;
        else
            sy = HB'(sy_s);
    end

    assign src_addr = PB'(sy) * PB'(img_w) + PB'(sx);

    always_ff @(posedge clk)
    begin
        if (coef_we)
            kmem[coef_addr] <= coef_data;
        ker_q <= kmem[k_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        pix_next   = pix_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = C_RUN;
                    x_next     = '0;
                    y_next     = '0;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    pix_next   = '0;
                end
            end
            C_RUN:
            begin
                if (tap_last)
                begin
                    i_next   = '0;
                    j_next   = '0;
                    k_next   = '0;
                    pix_next = pix_reg + 1'b1;
                    if (col_last)
                    begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                        if (row_last)
                            state_next = C_DRAIN;
                    end
                    else
                        x_next = x_reg + 1'b1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    if (j_reg == klast)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            C_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                    state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        acc_next = (p2_first_reg ? '0 : acc_reg) + FILT_W'(prod_reg);
        acc_abs  = acc_next[FILT_W-1] ? FILT_W'(-acc_next) : FILT_W'(acc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= C_IDLE;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            max_src_reg  <= '0;
            max_abs_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            if (start)
            begin
                max_src_reg <= '0;
                max_abs_reg <= '0;
            end
            else
            begin
                // the center tap reads the pixel itself
                if (p1_valid_reg && p1_center_reg && src_data > max_src_reg)
                    max_src_reg <= src_data;
                if (p2_valid_reg && p2_last_reg && acc_abs > max_abs_reg)
                    max_abs_reg <= acc_abs;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        pix_reg       <= pix_next;
        p1_first_reg  <= (i_reg == '0) && (j_reg == '0);
        p1_last_reg   <= tap_last;
        p1_center_reg <= (i_reg == anchor) && (j_reg == anchor);
        p1_pix_reg    <= pix_reg;
        p2_first_reg  <= p1_first_reg;
        p2_last_reg   <= p1_last_reg;
        p2_pix_reg    <= p1_pix_reg;
        prod_reg      <= ker_q * $signed({1'b0, src_data});
        if (p2_valid_reg)
            acc_reg <= acc_next;
    end

    assign filt_we   = p2_valid_reg && p2_last_reg;
    assign filt_addr = p2_pix_reg;
    assign filt_data = acc_next;
    assign max_src   = max_src_reg;
    assign max_abs   = max_abs_reg;
    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_DRAIN) && !p1_valid_reg && !p2_valid_reg;

endmodule

// File: rtl/log_unsharp_mask_normalized_unit.sv
// Loads (coefficient or pixel) are taken one per cycle while idle; one word is in work at a time.
// The first fetch after any load or register write, or after the last pixel's fetch, first
// runs the convolution pass, one kernel tap per cycle through the source memory port.
// A fetch then runs a read, two multiplies and a 32-step serial divide (no divide when the
// largest filtered magnitude is zero); the word then holds in the output register until taken.
// rst_n clears control and maxima; image, kernel and filtered memories stay undefined.
module log_unsharp_mask_normalized_unit #(
    parameter int MAX_WIDTH  = ulsm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ulsm_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_KERNEL = ulsm_pkg::DEF_MAX_KERNEL
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic [6:0]                        coef_index,
    input  logic signed [ulsm_pkg::COEF_W-1:0] coef_value,
    input  logic [ulsm_pkg::SRC_W-1:0]        pixel_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ulsm_pkg::OUT_W-1:0] out_pixel,
    output logic                              last_pixel
);
    import ulsm_pkg::*;

    localparam int WB     = $clog2(MAX_WIDTH + 1);
    localparam int HB     = $clog2(MAX_HEIGHT + 1);
    localparam int LB     = $clog2(MAX_KERNEL + 1);
    localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int KB     = $clog2(KDEPTH);
    localparam int SDEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PB     = $clog2(SDEPTH);
    localparam int NB     = $clog2(SDEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_DIVGO = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [8:0]        width_reg, height_reg;
    logic [3:0]        klen_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic [LB-1:0] l_eff;
    logic [NB-1:0] n_eff;

    logic [2:0]    state_reg, state_next;
    logic [NB-1:0] load_cnt_reg, load_cnt_next;
    logic [NB-1:0] fetch_cnt_reg, fetch_cnt_next;
    logic          pass_done_reg, pass_done_next;

    logic [SRC_W-1:0]  src_mem [SDEPTH];
    logic [FILT_W-1:0] filt_mem [SDEPTH];
    logic [SRC_W-1:0]  src_q;
    logic [FILT_W-1:0] filt_q;
    logic [PB-1:0]     src_raddr, conv_addr, filt_waddr;
    logic              filt_we;
    logic [FILT_W-1:0] filt_wdata;

    logic [SRC_W-1:0]  max_src;
    logic [FILT_W-1:0] max_abs;
    logic              conv_start;
    unit_stat_t        conv_stat, div_stat;
    logic              coef_we;

    logic [SRC_W-1:0]  src_hold_reg;
    logic              neg_reg, last_reg, mzero_reg;
    logic [T1_W-1:0]   t1_reg;
    logic [T2_W-1:0]   t2_reg;
    logic [FILT_W-1:0] filt_abs;
    logic [QUOT_W-1:0] quot;

    logic [QUOT_W:0]         rounded;
    logic [DELTA_W-1:0]      delta;
    logic signed [SUM_W-1:0] sum;
    logic signed [OUT_W-1:0] res;

    logic              in_acc, out_free;
    logic              out_valid_reg;
    logic signed [OUT_W-1:0] out_pixel_reg;
    logic              last_pixel_reg;

    // out-of-range register values act as the nearest legal value
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WB'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = WB'(MAX_WIDTH);
        else
            w_eff = WB'(width_reg);
        if (height_reg == '0)
            h_eff = HB'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = HB'(MAX_HEIGHT);
        else
            h_eff = HB'(height_reg);
        if (klen_reg == '0)
            l_eff = LB'(1);
        else if (32'(klen_reg) > 32'(MAX_KERNEL))
            l_eff = LB'(MAX_KERNEL);
        else
            l_eff = LB'(klen_reg);
        n_eff = NB'(w_eff) * NB'(h_eff);
    end

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign coef_we  = in_acc && (opcode == OP_COEF) && (32'(coef_index) < 32'(KDEPTH));
    assign src_raddr = (state_reg == S_PASS) ? conv_addr : fetch_cnt_reg[PB-1:0];

    always_ff @(posedge clk)
    begin
        if (in_acc && opcode == OP_PIXEL)
            src_mem[load_cnt_reg[PB-1:0]] <= pixel_value;
        src_q <= src_mem[src_raddr];
        if (filt_we)
            filt_mem[filt_waddr] <= filt_wdata;
        filt_q <= filt_mem[fetch_cnt_reg[PB-1:0]];
    end

    ulsm_conv #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (conv_start),
        .img_w     (w_eff),
        .img_h     (h_eff),
        .klen      (l_eff),
        .coef_we   (coef_we),
        .coef_addr (KB'(coef_index)),
        .coef_data (coef_value),
        .src_addr  (conv_addr),
        .src_data  (src_q),
        .filt_we   (filt_we),
        .filt_addr (filt_waddr),
        .filt_data (filt_wdata),
        .max_src   (max_src),
        .max_abs   (max_abs),
        .stat      (conv_stat)
    );

    ulsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DIVGO),
        .num   (t2_reg),
        .den   (max_abs),
        .quot  (quot),
        .stat  (div_stat)
    );

    assign conv_start = in_acc && (opcode == OP_FETCH) && !pass_done_reg;

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        fetch_cnt_next = fetch_cnt_reg;
        pass_done_next = pass_done_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (opcode)
                        OP_COEF:
                        begin
                            fetch_cnt_next = '0;
                            pass_done_next = 1'b0;
                        end
                        OP_PIXEL:
                        begin
                            load_cnt_next  = (load_cnt_reg + 1'b1 >= n_eff) ? '0
                                                                          : load_cnt_reg + 1'b1;
                            fetch_cnt_next = '0;
                            pass_done_next = 1'b0;
                        end
                        OP_FETCH:
                        begin
                            state_next = pass_done_reg ? S_ISSUE : S_PASS;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_PASS:
            begin
                if (conv_stat.done)
                begin
                    pass_done_next = 1'b1;
                    fetch_cnt_next = '0;
                    state_next     = S_ISSUE;
                end
            end
            S_ISSUE: state_next = S_MUL1;
            S_MUL1:
            begin
                if (fetch_cnt_reg + 1'b1 >= n_eff)
                begin
                    fetch_cnt_next = '0;
                    pass_done_next = 1'b0;
                end
                else
                    fetch_cnt_next = fetch_cnt_reg + 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:  state_next = mzero_reg ? S_DONE : S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (cfg_write_en)
        begin
            load_cnt_next  = '0;
            fetch_cnt_next = '0;
            pass_done_next = 1'b0;
        end
    end

    always_comb
    begin
        filt_abs = filt_q[FILT_W-1] ? FILT_W'(-filt_q) : filt_q;
        rounded  = {1'b0, quot} + ROUND_BIAS;
        delta    = mzero_reg ? '0 : DELTA_W'(rounded >> RND_SH);
        if (neg_reg)
            sum = SUM_W'(src_hold_reg) - SUM_W'(delta);
        else
            sum = SUM_W'(src_hold_reg) + SUM_W'(delta);
        if (sum > OUT_MAX)
            res = OUT_W'(OUT_MAX);
        else if (sum < OUT_MIN)
            res = OUT_W'(OUT_MIN);
        else
            res = OUT_W'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            load_cnt_reg  <= '0;
            fetch_cnt_reg <= '0;
            pass_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            klen_reg      <= 4'd5;
            gain_reg      <= 16'd4096;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            fetch_cnt_reg <= fetch_cnt_next;
            pass_done_reg <= pass_done_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   width_reg  <= cfg_data[8:0];
                    REG_IMAGE_HEIGHT:  height_reg <= cfg_data[8:0];
                    REG_KERNEL_LENGTH: klen_reg   <= cfg_data[3:0];
                    REG_SHARPEN_GAIN:  gain_reg   <= cfg_data;
                    default: width_reg <= width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL1)
        begin
            src_hold_reg <= src_q;
            neg_reg      <= filt_q[FILT_W-1];
            mzero_reg    <= (max_abs == '0);
            last_reg     <= (fetch_cnt_reg + 1'b1 >= n_eff);
            t1_reg       <= filt_abs * max_src;
        end
        if (state_reg == S_MUL2)
            t2_reg <= t1_reg * gain_reg;
        if (state_reg == S_DONE && out_free)
        begin
            out_pixel_reg  <= res;
            last_pixel_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign last_pixel = last_pixel_reg;

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ulsm_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int KMAX = DEF_MAX_KERNEL;
    localparam int WMAX = DEF_MAX_WIDTH;
    localparam int HMAX = DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int ITEM_TARGET = 1550;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] opcode = '0;
    logic [6:0] coef_index = '0;
    logic signed [COEF_W-1:0] coef_value = '0;
    logic [SRC_W-1:0] pixel_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [OUT_W-1:0] out_pixel;
    logic last_pixel;

    log_unsharp_mask_normalized_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .coef_index(coef_index),
        .coef_value(coef_value),
        .pixel_value(pixel_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_pixel(out_pixel),
        .last_pixel(last_pixel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct {
        logic signed [OUT_W-1:0] pix;
        logic last;
    } sharp_word_t;

    sharp_word_t sharp_q[$];
    int mismatches = 0;
    int cycles = 0;
    int n_sent = 0;
    bit quiet = 1'b0;
    int hold_req = 0;

    // model of the unit
    logic [15:0] src_mem [0:WMAX*HMAX-1];
    logic signed [15:0] kern_mem [0:KMAX*KMAX-1];
    longint filt_mem [0:WMAX*HMAX-1];
    int unsigned load_ptr, fetch_ptr;
    longint unsigned max_src, max_filt;
    bit filtered_ok;
    logic [8:0] img_w, img_h;
    logic [3:0] ker_len;
    logic [15:0] gain;

    function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int clip(int v, int n);
        if (v < 0)
            return 0;
        if (v >= n)
            return n - 1;
        return v;
    endfunction

    function automatic void filter_image(int w, int h, int len);
        int c;
        int sy, sx;
        longint acc;
        longint unsigned mag;
        c = (len - 1) / 2;
        max_src = 0;
        max_filt = 0;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
            begin
                acc = 0;
                if (src_mem[y*w+x] > max_src)
                    max_src = src_mem[y*w+x];
                for (int i = 0; i < len; i++)
                begin
                    sy = clip(y + c - i, h);
                    for (int j = 0; j < len; j++)
                    begin
                        sx = clip(x + c - j, w);
                        acc += longint'(kern_mem[i*len+j]) * longint'({1'b0, src_mem[sy*w+sx]});
                    end
                end
                filt_mem[y*w+x] = acc;
                mag = (acc < 0) ? longint'(-acc) : acc;
                if (mag > max_filt)
                    max_filt = mag;
            end
        filtered_ok = 1'b1;
    endfunction

    function automatic logic signed [OUT_W-1:0] sharpen(logic [15:0] s, longint f);
        longint unsigned mag, prod, quo, rem, scaled;
        longint d, o;
        o = s;
        if (max_filt != 0)
        begin
            mag = (f < 0) ? longint'(-f) : f;
            prod = mag * max_src;
            quo = prod / max_filt;
            rem = prod % max_filt;
            scaled = quo * gain + (rem * gain) / max_filt;
            d = (scaled + 2048) >> 12;
            o = (f < 0) ? o - d : o + d;
        end
        if (o > 2097151)
            o = 2097151;
        if (o < -2097152)
            o = -2097152;
        return o[OUT_W-1:0];
    endfunction

    function automatic bit sharpen_step(logic [1:0] op, logic [6:0] idx,
                                        logic [15:0] cval, logic [15:0] pix,
                                        output sharp_word_t res);
        int unsigned w, h, len, n;
        w = eff_size(img_w, WMAX);
        h = eff_size(img_h, HMAX);
        len = eff_size(ker_len, KMAX);
        n = w * h;
        res.pix = '0;
        res.last = 1'b0;
        case (op)
            OP_COEF:
            begin
                if (idx < KMAX*KMAX)
                    kern_mem[idx] = cval;
                fetch_ptr = 0;
                filtered_ok = 1'b0;
                return 1'b0;
            end
            OP_PIXEL:
            begin
                if (load_ptr >= n)
                    load_ptr = 0;
                src_mem[load_ptr] = pix;
                load_ptr = (load_ptr + 1 >= n) ? 0 : load_ptr + 1;
                fetch_ptr = 0;
                filtered_ok = 1'b0;
                return 1'b0;
            end
            OP_FETCH:
            begin
                if (!filtered_ok)
                begin
                    filter_image(w, h, len);
                    fetch_ptr = 0;
                end
                if (fetch_ptr >= n)
                    fetch_ptr = 0;
                res.pix = sharpen(src_mem[fetch_ptr], filt_mem[fetch_ptr]);
                res.last = (fetch_ptr + 1 >= n);
                if (res.last)
                begin
                    fetch_ptr = 0;
                    filtered_ok = 1'b0;
                end
                else
                    fetch_ptr++;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // sender: one word per call, valid held high across back-to-back words
    task automatic send_word(logic [1:0] op, logic [6:0] idx, logic [15:0] cval,
                             logic [15:0] pix, bit typed = 0,
                             logic signed [OUT_W-1:0] t_pix = '0, logic t_last = 0);
        sharp_word_t res;
        if (!quiet && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        coef_index <= idx;
        coef_value <= cval;
        pixel_value <= pix;
        if (sharpen_step(op, idx, cval, pix, res))
        begin
            if (typed)
            begin
                res.pix = t_pix;
                res.last = t_last;
            end
            sharp_q.push_back(res);
        end
        n_sent++;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (sharp_q.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_regs(logic [8:0] w, logic [8:0] h, logic [3:0] len,
                              logic [15:0] g);
        logic [15:0] val [4];
        val[REG_IMAGE_WIDTH] = {7'($urandom), w};
        val[REG_IMAGE_HEIGHT] = {7'($urandom), h};
        val[REG_KERNEL_LENGTH] = {12'($urandom), len};
        val[REG_SHARPEN_GAIN] = g;
        for (int i = 0; i < 4; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_write_en <= 1'b0;
        img_w = w;
        img_h = h;
        ker_len = len;
        gain = g;
        load_ptr = 0;
        fetch_ptr = 0;
        filtered_ok = 1'b0;
    endtask

    function automatic logic [15:0] rand_pix();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    typedef struct {
        logic [1:0] op;
        logic [6:0] idx;
        logic [15:0] cval;
        logic [15:0] pix;
        bit typed;
        logic signed [OUT_W-1:0] t_pix;
        logic t_last;
    } stim_row_t;

    stim_row_t rows[$];

    function automatic void row(logic [1:0] op, logic [6:0] idx, logic [15:0] cval,
                                logic [15:0] pix, bit typed = 0,
                                logic signed [OUT_W-1:0] t_pix = '0, logic t_last = 0);
        rows.push_back('{op, idx, cval, pix, typed, t_pix, t_last});
    endfunction

    initial
    begin
        int unsigned w, h, len, n, nf;
        logic [8:0] rw, rh;
        logic [3:0] rl;
        logic [15:0] rg;
        int phase;
        img_w = 256;
        img_h = 256;
        ker_len = 5;
        gain = 4096;
        load_ptr = 0;
        fetch_ptr = 0;
        max_src = 0;
        max_filt = 0;
        filtered_ok = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero kernel leaves the source untouched
        write_regs(9'd2, 9'd2, 4'd1, 16'd4096);
        row(OP_COEF, 7'd0, 16'h0000, 16'h0);
        row(OP_COEF, 7'd127, 16'h7FFF, 16'h0);
        row(OP_PIXEL, 7'd0, 16'h0, 16'h0000);
        row(OP_PIXEL, 7'd0, 16'h0, 16'hFFFF);
        row(OP_PIXEL, 7'd0, 16'h0, 16'h1234);
        row(OP_PIXEL, 7'd0, 16'h0, 16'h8000);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0, 1, 0, 0);
        row(OP_NONE, 7'h7F, 16'hFFFF, 16'hFFFF);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0, 1, 65535, 0);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0, 1, 'h1234, 0);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0, 1, 'h8000, 1);
        // wrap after the last pixel starts a new pass
        row(OP_FETCH, 7'd0, 16'h0, 16'h0, 1, 0, 0);
        row(OP_COEF, 7'd0, 16'h8000, 16'h0);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0);
        row(OP_PIXEL, 7'd0, 16'h0, 16'h00FF);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0);
        row(OP_COEF, 7'd0, 16'h7FFF, 16'h0);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0);
        row(OP_FETCH, 7'd0, 16'h0, 16'h0);
        foreach (rows[i])
            send_word(rows[i].op, rows[i].idx, rows[i].cval, rows[i].pix,
                      rows[i].typed, rows[i].t_pix, rows[i].t_last);
        drain();

        phase = 0;
        while (n_sent < ITEM_TARGET || phase < 7)
        begin
            rw = 9'($urandom_range(1, 8));
            rh = 9'($urandom_range(1, 8));
            rl = 4'(2 * $urandom_range(0, 4) + 1);
            if ($urandom_range(0, 4) == 0)
                rl = 4'($urandom);
            rg = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8192)) : 16'($urandom);
            case (phase)
                0: begin rw = 3; rh = 2; rl = 3; end
                1: begin rw = 0; rh = 0; rl = 0; rg = 16'h0000; end
                2: begin rw = 9'h1FF; rh = 1; rl = 9; rg = 16'hFFFF; end
                3: begin rw = 1; rh = 256; rl = 4'hF; end
                4: begin rw = 40; rh = 2; rl = 1; end
                5: begin rw = 4; rh = 3; end
                6: begin rw = 8; rh = 8; end
                default: ;
            endcase
            quiet = (phase == 6);
            write_regs(rw, rh, rl, rg);
            w = eff_size(rw, WMAX);
            h = eff_size(rh, HMAX);
            len = eff_size(rl, KMAX);
            n = w * h;
            for (int i = 0; i < n; i++)
                send_word(OP_PIXEL, 7'($urandom), 16'($urandom), rand_pix());
            if (phase == 0)
                for (int i = 0; i < KMAX*KMAX; i++)
                    send_word(OP_COEF, 7'(i), 16'($urandom), 16'($urandom));
            else
                repeat ($urandom_range(0, 6))
                    send_word(OP_COEF, 7'($urandom_range(0, len*len - 1)),
                              16'($urandom), 16'($urandom));
            if (phase == 5)
                hold_req++;
            nf = (n > 64) ? n + 3 : n + $urandom_range(0, n + 4);
            for (int i = 0; i < nf; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    case ($urandom_range(0, 2))
                        0: send_word(OP_NONE, 7'($urandom), 16'($urandom), 16'($urandom));
                        1: send_word(OP_COEF, 7'($urandom), 16'($urandom), 16'($urandom));
                        default: send_word(OP_PIXEL, 7'($urandom), 16'($urandom), rand_pix());
                    endcase
                send_word(OP_FETCH, 7'($urandom), 16'($urandom), 16'($urandom));
            end
            drain();
            phase++;
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // receiver back-pressure
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = 2000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 38);
        end
    end

    always @(posedge clk)
    begin
        sharp_word_t want;
        if (out_valid && !out_stall)
        begin
            if (sharp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: pix %0d last %0b", out_pixel, last_pixel);
            end
            else
            begin
                want = sharp_q.pop_front();
                if (out_pixel !== want.pix || last_pixel !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pix exp %0d got %0d, last exp %0b got %0b",
                                 want.pix, out_pixel, want.last, last_pixel);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// File: log_unsharp_mask_normalized_unit.f
rtl/ulsm_pkg.sv
rtl/ulsm_div.sv
rtl/ulsm_conv.sv
rtl/log_unsharp_mask_normalized_unit.sv
tb/tb.sv
